// ----- sv/imm_pkg.sv -----
// Shared types and codes for the integer matrix multiply block.
// No dependencies; imported by imm_cell, integer_matrix_multiply and the testbench.
`timescale 1ns / 1ps

package imm_pkg;

  localparam int DATA_W = 32;
  localparam int DIM_W  = 4;
  localparam int IDX_W  = 3;

  // opcodes of an input item
  localparam logic [1:0] OP_WRITE_A = 2'd0;
  localparam logic [1:0] OP_WRITE_B = 2'd1;
  localparam logic [1:0] OP_RUN     = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic [IDX_W-1:0]        elem_row;
    logic [IDX_W-1:0]        elem_col;
    logic signed [DATA_W-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [DATA_W-1:0] out_value;
    logic                    mismatch;
    logic                    last;
  } out_item_t;

  // A element travelling down the chain of cells
  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [IDX_W-1:0]  k;
    logic              vld;
  } cell_link_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic shift;
    logic mm;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN,
    ST_EMIT
  } ctl_state_t;

endpackage

// ----- sv/imm_cell.sv -----
// One cell of the multiply chain: holds column IDX of B and one accumulator.
// Depends on imm_pkg.
`timescale 1ns / 1ps

module imm_cell #(
  parameter int MAX_DIM = 8,
  parameter int IDX     = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  imm_pkg::cell_ctl_t                 ctl,
  input  logic                               b_we,
  input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] b_row,
  input  logic [imm_pkg::DATA_W-1:0]         b_data,
  input  imm_pkg::cell_link_t                link_in,
  output imm_pkg::cell_link_t                link_out,
  input  logic [imm_pkg::DATA_W-1:0]         acc_in,
  output logic [imm_pkg::DATA_W-1:0]         acc_out
);
  import imm_pkg::*;

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [DATA_W-1:0] bcol [MAX_DIM];
  logic [DATA_W-1:0] bsel;
  logic [DATA_W-1:0] prod;
  logic              pv;
  logic              pclr;
  logic [DATA_W-1:0] acc;
  cell_link_t        link_q;

  assign bsel     = bcol[link_in.k[IW-1:0]];
  assign link_out = link_q;
  assign acc_out  = acc;

  always_ff @(posedge clk) begin
    if (b_we) begin
      bcol[b_row] <= b_data;
    end
  end

  // pass A on, multiply into a register, then accumulate the registered product
  always_ff @(posedge clk) begin
    if (rst) begin
      link_q.vld <= 1'b0;
      pv         <= 1'b0;
    end else begin
      link_q.vld <= link_in.vld;
      pv         <= link_in.vld && !ctl.mm;
    end
    link_q.a <= link_in.a;
    link_q.k <= link_in.k;
    prod     <= link_in.a * bsel;
    pclr     <= (link_in.k == '0);
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      acc <= acc_in;
    end else if (ctl.mm && link_in.vld && (link_in.k == IDX_W'(IDX))) begin
      acc <= link_in.a;                 // mismatch: capture A[i][IDX]
    end else if (pv) begin
      acc <= (pclr ? '0 : acc) + prod;
    end
  end

endmodule

// ----- sv/integer_matrix_multiply.sv -----
// Integer matrix multiply top level: register port, A store, control, cell chain.
// Depends on imm_pkg and imm_cell.
//
// Usage:
//  - Registers a_rows, a_cols, b_rows, b_cols (APB, byte addresses 0/4/8/12)
//    set the matrix shapes; 0 acts as 1, values above MAX_DIM act as MAX_DIM.
//  - Input items: op WRITE_A / WRITE_B store one element (no result);
//    op RUN emits A*B row-major, one result item per element, last on the end.
//    If a_cols differs from b_rows, A itself is emitted with mismatch set.
//  - Phases of a run, per row of the result: the A row is streamed out of the
//    A store into the chain, the chain is drained (A hop per cell, multiply
//    register, accumulate), then one result element is emitted per cycle
//    while the receiver takes them. The chain length sets the drain time;
//    the single A store read port sets the feed rate.
//  - A new item is taken only while no run is in progress.
//  - A stalled receiver holds the output register; the cells hold their sums
//    until each one is taken, so nothing is lost.
//  - Reset (rst, synchronous) sets all four shapes to 8 and clears control;
//    the A and B stores are not cleared and must be written before use.
`timescale 1ns / 1ps

module integer_matrix_multiply #(
  parameter int MAX_DIM = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // input items
  input  logic                  in_valid,
  output logic                  in_ready,
  input  imm_pkg::in_item_t     in_item,
  // result items
  output logic                  out_valid,
  input  logic                  out_ready,
  output imm_pkg::out_item_t    out_item
);
  import imm_pkg::*;

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (v > DIM_MAX) begin
      return DIM_MAX;
    end
    return v;
  endfunction

  // ---------------- configuration registers ----------------
  logic [DIM_W-1:0] a_rows, a_cols, b_rows, b_cols;
  logic             cfg_we;
  logic [1:0]       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= DIM_W'(8);
      a_cols <= DIM_W'(8);
      b_rows <= DIM_W'(8);
      b_cols <= DIM_W'(8);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_A_ROWS: a_rows <= pwdata[DIM_W-1:0];
        REG_A_COLS: a_cols <= pwdata[DIM_W-1:0];
        REG_B_ROWS: b_rows <= pwdata[DIM_W-1:0];
        REG_B_COLS: b_cols <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_A_ROWS: prdata = 32'(a_rows);
      REG_A_COLS: prdata = 32'(a_cols);
      REG_B_ROWS: prdata = 32'(b_rows);
      REG_B_COLS: prdata = 32'(b_cols);
      default:    prdata = '0;
    endcase
  end

  // ---------------- control ----------------
  ctl_state_t       state, state_next;
  logic [IW-1:0]    row_cnt, k_cnt, col_cnt;
  logic [DW-1:0]    drain_cnt;
  logic [DIM_W-1:0] ar_eff, ac_eff, emit_n;
  logic             mm;
  logic             start, rd_en, emit;
  logic             k_last, col_last, row_last, drain_last;
  logic             in_fire, in_range;

  assign in_fire    = in_valid && in_ready;
  assign in_range   = ({1'b0, in_item.elem_row} < (IDX_W + 1)'(MAX_DIM)) &&
                      ({1'b0, in_item.elem_col} < (IDX_W + 1)'(MAX_DIM));
  assign k_last     = (DIM_W'(k_cnt) == ac_eff - DIM_W'(1));
  assign col_last   = (DIM_W'(col_cnt) == emit_n - DIM_W'(1));
  assign row_last   = (DIM_W'(row_cnt) == ar_eff - DIM_W'(1));
  assign drain_last = (drain_cnt == DW'(MAX_DIM));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_FEED;
      ST_FEED:  if (k_last) state_next = ST_DRAIN;
      ST_DRAIN: if (drain_last) state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit && col_last) begin
          state_next = row_last ? ST_IDLE : ST_FEED;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    start    = (state == ST_IDLE) && in_valid && (in_item.op == OP_RUN);
    rd_en    = (state == ST_FEED);
    emit     = (state == ST_EMIT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ar_eff  <= eff_dim(a_rows);
      ac_eff  <= eff_dim(a_cols);
      mm      <= (eff_dim(a_cols) != eff_dim(b_rows));
      emit_n  <= (eff_dim(a_cols) != eff_dim(b_rows)) ? eff_dim(a_cols)
                                                      : eff_dim(b_cols);
      row_cnt <= '0;
      k_cnt   <= '0;
    end
    if (state == ST_FEED) begin
      k_cnt     <= k_last ? '0 : k_cnt + IW'(1);
      drain_cnt <= '0;
    end
    if (state == ST_DRAIN) begin
      drain_cnt <= drain_cnt + DW'(1);
      col_cnt   <= '0;
    end
    if (emit) begin
      col_cnt <= col_cnt + IW'(1);
      if (col_last && !row_last) begin
        row_cnt <= row_cnt + IW'(1);
      end
    end
  end

  // ---------------- A store ----------------
  logic [DATA_W-1:0] a_mem [MAX_DIM * MAX_DIM];
  logic [DATA_W-1:0] a_rd;
  logic              rd_vld;
  logic [IW-1:0]     rd_k;
  logic              a_we;
  logic [AW-1:0]     a_waddr, a_raddr;

  assign a_we    = in_fire && (in_item.op == OP_WRITE_A) && in_range;
  assign a_waddr = AW'(in_item.elem_row * MAX_DIM + in_item.elem_col);
  assign a_raddr = AW'(row_cnt * MAX_DIM + k_cnt);

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[a_waddr] <= in_item.elem_value;
    end
    if (rd_en) begin
      a_rd <= a_mem[a_raddr];
    end
    rd_k <= k_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
    end
  end

  // ---------------- chain of cells ----------------
  cell_link_t        link [MAX_DIM + 1];
  logic [DATA_W-1:0] acc  [MAX_DIM + 1];
  cell_ctl_t         ctl;

  assign ctl.shift    = emit;
  assign ctl.mm       = mm;
  assign link[0].a    = a_rd;
  assign link[0].k    = IDX_W'(rd_k);
  assign link[0].vld  = rd_vld;
  assign acc[MAX_DIM] = '0;

  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    logic b_we;
    assign b_we = in_fire && (in_item.op == OP_WRITE_B) && in_range &&
                  (in_item.elem_col == IDX_W'(j));
    imm_cell #(
      .MAX_DIM (MAX_DIM),
      .IDX     (j)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .b_we     (b_we),
      .b_row    (IW'(in_item.elem_row)),
      .b_data   (in_item.elem_value),
      .link_in  (link[j]),
      .link_out (link[j+1]),
      .acc_in   (acc[j+1]),
      .acc_out  (acc[j])
    );
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item.out_row   <= IDX_W'(row_cnt);
      out_item.out_col   <= IDX_W'(col_cnt);
      out_item.out_value <= acc[0];
      out_item.mismatch  <= mm;
      out_item.last      <= row_last && col_last;
    end
  end

`ifndef SYNTH
  // the drain must outlast the trip of the final A element down the chain
  a_chain_drained: assert property (@(posedge clk) disable iff (rst)
    link[MAX_DIM].vld |-> (state == ST_FEED || state == ST_DRAIN))
    else $error("A element still in chain outside feed/drain");

  // no A read in flight while sums are being emitted
  a_no_read_in_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> !rd_vld)
    else $error("A read data arrived during emit");

  // the final element of a run returns control to idle
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (emit && row_last && col_last) |=> (state == ST_IDLE))
    else $error("run did not end after last element");
`endif

endmodule

// ----- test/integer_matrix_multiply_tb.sv -----
// Self-checking testbench for integer_matrix_multiply: loads A and B, runs products.
// Depends on imm_pkg and the integer_matrix_multiply RTL; needs no files.
`timescale 1ns / 1ps

module integer_matrix_multiply_tb;
  import imm_pkg::*;

  localparam int DIM           = 8;     // MAX_DIM of the instance
  localparam int SETTLE_CYCLES = 32;    // covers a row of feed + chain drain
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_ITEMS  = 160;

  // op 3 has no name in the package; the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Tracks the A/B stores and shape registers, and queues the result
  // elements each run item must produce, in emission order.
  class matrix_scoreboard;
    bit [DATA_W-1:0] a_mem[DIM*DIM];
    bit [DATA_W-1:0] b_mem[DIM*DIM];
    bit [DIM_W-1:0]  shape[4];
    out_item_t       expected_elems[$];
    int              error_count;

    function new();
      foreach (shape[i]) shape[i] = 4'd8;
      foreach (a_mem[i]) begin
        a_mem[i] = '0;
        b_mem[i] = '0;
      end
      error_count = 0;
    endfunction

    // 0 acts as 1, anything above DIM acts as DIM
    static function int unsigned used_dim(bit [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > DIM) return DIM;
      return 32'(v);
    endfunction

    function void set_shape(logic [1:0] idx, bit [DIM_W-1:0] v);
      shape[idx] = v;
    endfunction

    function void note_item(in_item_t it);
      int unsigned ar, ac, br, bc;
      bit [DATA_W-1:0] acc;
      out_item_t e;
      case (it.op)
        OP_WRITE_A: a_mem[{it.elem_row, it.elem_col}] = it.elem_value;
        OP_WRITE_B: b_mem[{it.elem_row, it.elem_col}] = it.elem_value;
        OP_RUN: begin
          ar = used_dim(shape[REG_A_ROWS]);
          ac = used_dim(shape[REG_A_COLS]);
          br = used_dim(shape[REG_B_ROWS]);
          bc = used_dim(shape[REG_B_COLS]);
          if (ac != br) begin
            // inner sizes disagree: A comes back flagged
            for (int i = 0; i < ar; i++) begin
              for (int j = 0; j < ac; j++) begin
                e.out_row   = IDX_W'(i);
                e.out_col   = IDX_W'(j);
                e.out_value = a_mem[{IDX_W'(i), IDX_W'(j)}];
                e.mismatch  = 1'b1;
                e.last      = (i == ar - 1) && (j == ac - 1);
                expected_elems.push_back(e);
              end
            end
          end else begin
            for (int i = 0; i < ar; i++) begin
              for (int j = 0; j < bc; j++) begin
                acc = '0;
                for (int k = 0; k < ac; k++)
                  acc = acc + a_mem[{IDX_W'(i), IDX_W'(k)}] *
                              b_mem[{IDX_W'(k), IDX_W'(j)}];  // wraps at 32 bits
                e.out_row   = IDX_W'(i);
                e.out_col   = IDX_W'(j);
                e.out_value = acc;
                e.mismatch  = 1'b0;
                e.last      = (i == ar - 1) && (j == bc - 1);
                expected_elems.push_back(e);
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void flag_error(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%t ERROR: %s", $realtime, msg);
    endfunction

    function void check_elem(out_item_t got);
      out_item_t want;
      if (expected_elems.size() == 0) begin
        flag_error($sformatf("unexpected result row %0d col %0d value %0d mm %0b last %0b",
                             got.out_row, got.out_col, got.out_value, got.mismatch,
                             got.last));
        return;
      end
      want = expected_elems.pop_front();
      if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
          got.out_value !== want.out_value || got.mismatch !== want.mismatch ||
          got.last !== want.last)
        flag_error($sformatf({"expected row %0d col %0d value %0d mm %0b last %0b, ",
                              "got row %0d col %0d value %0d mm %0b last %0b"},
                             want.out_row, want.out_col, want.out_value, want.mismatch,
                             want.last, got.out_row, got.out_col, got.out_value,
                             got.mismatch, got.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;

  matrix_scoreboard board;
  int          idle_pct = 10;     // shared by sender and receiver; 0 in calm stretches
  int          sent_items = 0;    // items that do something (op 3 excluded)
  bit          a_done[DIM*DIM];   // entries written since reset
  bit          b_done[DIM*DIM];

  integer_matrix_multiply #(.MAX_DIM(DIM)) dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: stalls at random unless in a calm stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Both handshakes are sampled on pre-edge values; inputs are noted first so
  // a run's expectations exist before any of its results can show up.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_item(in_item);
      if (out_valid && out_ready) board.check_elem(out_item);
    end
  end

  // Mix of extremes, zero, small signed and full random.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0;
      3:       return 32'hFFFF_FFFF;
      4, 5:    return $urandom_range(20) - 10;
      default: return $urandom;
    endcase
  endfunction

  // One item over the valid/ready channel. Valid stays up between
  // back-to-back items; it only drops when an idle gap is taken.
  task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [31:0] value);
    in_item_t it;
    it.op         = op;
    it.elem_row   = row;
    it.elem_col   = col;
    it.elem_value = value;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_WRITE_A) a_done[{row, col}] = 1'b1;
    if (op == OP_WRITE_B) b_done[{row, col}] = 1'b1;
    if (op != OP_UNUSED) sent_items++;
  endtask

  // Block idle: no result owed, then enough cycles for a trailing write to land.
  // The first edge lets the monitor note an item taken at the previous edge.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready, then back to idle.
  // Upper data bits are junk half the time; only the low nibble is the register.
  task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
    logic [31:0] data;
    data = $urandom_range(1) ? $urandom : 32'd0;
    data[DIM_W-1:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_shape(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_shapes(input logic [DIM_W-1:0] ar, input logic [DIM_W-1:0] ac,
                            input logic [DIM_W-1:0] br, input logic [DIM_W-1:0] bc);
    settle();
    write_reg(REG_A_ROWS, ar);
    write_reg(REG_A_COLS, ac);
    write_reg(REG_B_ROWS, br);
    write_reg(REG_B_COLS, bc);
  endtask

  // Writes every operand entry the next run reads that is still unwritten,
  // and refreshes some of the others so results keep changing.
  task automatic load_operands();
    int unsigned ar, ac, br, bc;
    ar = matrix_scoreboard::used_dim(board.shape[REG_A_ROWS]);
    ac = matrix_scoreboard::used_dim(board.shape[REG_A_COLS]);
    br = matrix_scoreboard::used_dim(board.shape[REG_B_ROWS]);
    bc = matrix_scoreboard::used_dim(board.shape[REG_B_COLS]);
    for (int i = 0; i < ar; i++)
      for (int k = 0; k < ac; k++)
        if (!a_done[{IDX_W'(i), IDX_W'(k)}] || $urandom_range(99) < 25)
          send_item(OP_WRITE_A, IDX_W'(i), IDX_W'(k), pick_value());
    // B is only read when the shapes agree
    if (ac == br)
      for (int k = 0; k < br; k++)
        for (int j = 0; j < bc; j++)
          if (!b_done[{IDX_W'(k), IDX_W'(j)}] || $urandom_range(99) < 25)
            send_item(OP_WRITE_B, IDX_W'(k), IDX_W'(j), pick_value());
  endtask

  // Shape register value: mostly small, sometimes 0, the maximum or above it.
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(9))
      0:       return 4'd0;
      1:       return DIM_W'($urandom_range(15, 8));
      2:       return DIM_W'($urandom_range(8, 5));
      default: return DIM_W'($urandom_range(4, 1));
    endcase
  endfunction

  initial begin
    logic [DIM_W-1:0] ar, ac, br, bc;
    int phase;

    board = new();
    foreach (a_done[i]) begin
      a_done[i] = 1'b0;
      b_done[i] = 1'b0;
    end
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // 1x1: min*min wraps to zero, max*-1, ignored op 3, far-corner writes
    set_shapes(4'd1, 4'd1, 4'd1, 4'd1);
    send_item(OP_WRITE_A, 3'd0, 3'd0, 32'h8000_0000);
    send_item(OP_WRITE_B, 3'd0, 3'd0, 32'h8000_0000);
    send_item(OP_RUN, 3'd0, 3'd0, 32'd0);
    send_item(OP_WRITE_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
    send_item(OP_WRITE_B, 3'd0, 3'd0, 32'hFFFF_FFFF);
    send_item(OP_RUN, 3'd7, 3'd7, 32'hFFFF_FFFF);
    send_item(OP_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF);
    send_item(OP_RUN, 3'd0, 3'd0, 32'd0);
    send_item(OP_WRITE_A, 3'd7, 3'd7, 32'hFFFF_FFFF);
    send_item(OP_WRITE_B, 3'd7, 3'd7, 32'h7FFF_FFFF);
    send_item(OP_RUN, 3'd5, 3'd2, 32'h5555_5555);

    // 2x2 A against 1-row B: A returned flagged
    set_shapes(4'd2, 4'd2, 4'd1, 4'd1);
    send_item(OP_WRITE_A, 3'd0, 3'd1, 32'h5555_5555);
    send_item(OP_WRITE_A, 3'd1, 3'd0, 32'hAAAA_AAAA);
    send_item(OP_WRITE_A, 3'd1, 3'd1, 32'd0);
    send_item(OP_RUN, 3'd0, 3'd0, 32'd0);

    // 2x2 times 2x2
    set_shapes(4'd2, 4'd2, 4'd2, 4'd2);
    send_item(OP_WRITE_B, 3'd0, 3'd1, 32'hAAAA_AAAA);
    send_item(OP_WRITE_B, 3'd1, 3'd0, 32'h5555_5555);
    send_item(OP_WRITE_B, 3'd1, 3'd1, 32'hFFFF_FFFE);
    send_item(OP_RUN, 3'd2, 3'd5, 32'hAAAA_AAAA);

    // --- random phases ---
    // First phases pin the shape extremes; phases 3 and 4 run with no idling.
    sent_items = 0;
    phase = 0;
    while (sent_items < RANDOM_ITEMS) begin
      case (phase)
        0: begin  // 0 acts as 1, 15 as 8: 1x8 times 8x1
          ar = 4'd0; ac = 4'd15; br = 4'd8; bc = 4'd0;
        end
        1: begin  // full 8x8 A against 1-row B
          ar = 4'd8; ac = 4'd8; br = 4'd1; bc = 4'd3;
        end
        2: begin  // 8x1 times 1x8: the full 64 results
          ar = 4'd8; ac = 4'd1; br = 4'd1; bc = 4'd8;
        end
        default: begin
          ar = pick_dim();
          ac = pick_dim();
          bc = pick_dim();
          br = ($urandom_range(3) == 0) ? pick_dim() : ac;
        end
      endcase
      settle();
      idle_pct = (phase == 3 || phase == 4) ? 0 : 10;
      set_shapes(ar, ac, br, bc);
      repeat ($urandom_range(3, 1)) begin
        // noise: stray writes anywhere and ignored opcodes
        repeat ($urandom_range(3)) begin
          if ($urandom_range(9) < 3)
            send_item(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
          else
            send_item($urandom_range(1) ? OP_WRITE_B : OP_WRITE_A, IDX_W'($urandom),
                      IDX_W'($urandom), pick_value());
        end
        load_operands();
        send_item(OP_RUN, IDX_W'($urandom), IDX_W'($urandom), $urandom);
      end
      phase++;
    end

    settle();
    if (board.error_count == 0 && board.expected_elems.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
